@@ rtl/fss_pkg.sv @@
// Shared types, constants and helpers for the fuzzy subsequence score block.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package fss_pkg;

  localparam int QUERY_BYTES_W   = 64;
  localparam int QUERY_LENGTH_W  = 4;
  localparam int CHAR_W          = 8;
  localparam int SCORE_W         = 9;
  localparam int SUM_W           = 8;
  localparam int POS_W           = 4;
  localparam int SLOT_W          = 3;
  localparam int CFG_INDEX_W     = 1;
  localparam int DEF_MAX_QUERY   = 8;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] REG_QUERY_BYTES  = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_QUERY_LENGTH = 1'b1;

  // Score increments.
  localparam logic [SUM_W-1:0]   ADD_MATCH      = 8'd10;
  localparam logic [SUM_W-1:0]   ADD_RUN        = 8'd5;
  localparam logic [SUM_W-1:0]   ADD_BOUNDARY   = 8'd10;
  localparam logic [SCORE_W-1:0] BONUS_FIRST    = 9'd20;
  localparam logic [SCORE_W-1:0] BONUS_PREFIX   = 9'd30;
  localparam logic [SCORE_W-1:0] BONUS_EXACT    = 9'd50;
  localparam logic [SCORE_W-1:0] SCORE_EMPTY_Q  = 9'd1;
  localparam logic [SCORE_W-1:0] SCORE_NO_MATCH = 9'd0;
  localparam logic [POS_W-1:0]   COUNT_SAT      = 4'd9;

  localparam logic [CHAR_W-1:0] CHAR_SPACE      = 8'h20;
  localparam logic [CHAR_W-1:0] CHAR_UNDERSCORE = 8'h5F;
  localparam logic [CHAR_W-1:0] CHAR_HYPHEN     = 8'h2D;
  localparam logic [CHAR_W-1:0] CHAR_UPPER_A    = 8'h41;
  localparam logic [CHAR_W-1:0] CHAR_UPPER_Z    = 8'h5A;
  localparam logic [CHAR_W-1:0] CASE_OFFSET     = 8'h20;

  typedef struct packed {
    logic [POS_W-1:0]  query_position;
    logic [SUM_W-1:0]  score_sum;
    logic              previous_matched;
    logic [CHAR_W-1:0] previous_byte;
    logic [POS_W-1:0]  byte_count;
    logic              prefix_equal;
    logic              first_byte_matched;
  } fss_state_t;

  localparam fss_state_t STATE_CLEAR = '{
    query_position:     '0,
    score_sum:          '0,
    previous_matched:   1'b0,
    previous_byte:      '0,
    byte_count:         '0,
    prefix_equal:       1'b1,
    first_byte_matched: 1'b0
  };

  function automatic logic [CHAR_W-1:0] fold_lower(input logic [CHAR_W-1:0] c);
    if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
      return c + CASE_OFFSET;
    end
    return c;
  endfunction

endpackage

@@ rtl/fss_step.sv @@
// Per-byte update of the match state and the final score for a last item.
// Purely combinational; depends on fss_pkg.
`timescale 1ns / 1ps

module fss_step
  import fss_pkg::*;
#(
  parameter int MAX_QUERY = DEF_MAX_QUERY
) (
  input  fss_state_t                 state,
  input  logic [QUERY_BYTES_W-1:0]   query_bytes,
  input  logic [QUERY_LENGTH_W-1:0]  query_length,
  input  logic [CHAR_W-1:0]          text_byte,
  input  logic                       byte_present,
  output fss_state_t                 state_next,
  output logic [SCORE_W-1:0]         score
);

  localparam logic [QUERY_LENGTH_W-1:0] MAX_LEN = QUERY_LENGTH_W'(MAX_QUERY);

  logic [QUERY_LENGTH_W-1:0] qlen;
  logic [CHAR_W-1:0]         c;
  logic [CHAR_W-1:0]         q_at_pos;
  logic [CHAR_W-1:0]         q_at_count;
  logic                      at_start;
  logic                      boundary;
  logic [SUM_W-1:0]          add;

  always_comb begin
    qlen       = (query_length > MAX_LEN) ? MAX_LEN : query_length;
    c          = fold_lower(text_byte);
    q_at_pos   = fold_lower(query_bytes[CHAR_W*state.query_position[SLOT_W-1:0] +: CHAR_W]);
    q_at_count = fold_lower(query_bytes[CHAR_W*state.byte_count[SLOT_W-1:0] +: CHAR_W]);
    at_start   = (state.byte_count == '0);
    boundary   = at_start || state.previous_byte == CHAR_SPACE ||
                 state.previous_byte == CHAR_UNDERSCORE || state.previous_byte == CHAR_HYPHEN;
    add = ADD_MATCH + (state.previous_matched ? ADD_RUN : '0) + (boundary ? ADD_BOUNDARY : '0);

    state_next = state;
    if (byte_present) begin
      if (state.query_position < qlen) begin
        if (c == q_at_pos) begin
          if (at_start) begin
            state_next.first_byte_matched = 1'b1;
          end
          state_next.score_sum        = state.score_sum + add;
          state_next.previous_matched = 1'b1;
          state_next.query_position   = state.query_position + 1'b1;
        end else begin
          state_next.previous_matched = 1'b0;
        end
      end
      if (state.byte_count < qlen && c != q_at_count) begin
        state_next.prefix_equal = 1'b0;
      end
      state_next.previous_byte = c;
      if (state.byte_count < COUNT_SAT) begin
        state_next.byte_count = state.byte_count + 1'b1;
      end
    end
  end

  // Final score is taken from the state after this item's byte is applied.
  always_comb begin
    priority if (qlen == '0) begin
      score = SCORE_EMPTY_Q;
    end else if (state_next.query_position < qlen) begin
      score = SCORE_NO_MATCH;
    end else begin
      score = {1'b0, state_next.score_sum}
            + (state_next.first_byte_matched ? BONUS_FIRST : '0)
            + ((state_next.prefix_equal && state_next.byte_count >= qlen) ? BONUS_PREFIX : '0)
            + ((state_next.prefix_equal && state_next.byte_count == qlen) ? BONUS_EXACT : '0);
    end
  end

endmodule

@@ rtl/fuzzy_subsequence_score_core.sv @@
// Top level of the fuzzy subsequence score block: configuration registers,
// stream state, input handshake and result register. Uses fss_pkg, fss_step.
`timescale 1ns / 1ps
//
// Usage:
//   Configure query_bytes (index 0) and query_length (index 1) through the
//   write port while the block is idle. Then stream text bytes on the input
//   channel (in_valid/in_ready), one byte per transfer; last_byte marks the
//   final transfer of a text and byte_present = 0 with last_byte = 1 ends an
//   empty text. Exactly one match_score comes out on the output channel per
//   text, in the cycle after the last transfer is accepted.
//   Throughput is one byte per cycle: the stream state is updated by a short
//   compare-and-add step at every accepted transfer, and the score lands in
//   a single output register. A new text may follow its predecessor without
//   a gap. When the receiver stalls, the pending score is held and in_ready
//   stays low until the score is taken, so every stalled cycle also holds
//   the input; in_ready is high whenever the register is empty or being drained.
//   Synchronous reset clears both configuration registers, the stream state
//   and the output valid flag.

module fuzzy_subsequence_score_core
  import fss_pkg::*;
#(
  parameter int MAX_QUERY = DEF_MAX_QUERY
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_write_enable,
  input  logic [CFG_INDEX_W-1:0]    cfg_index,
  input  logic [QUERY_BYTES_W-1:0]  cfg_data,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [CHAR_W-1:0]         text_byte,
  input  logic                      byte_present,
  input  logic                      last_byte,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [SCORE_W-1:0]        match_score
);

  logic [QUERY_BYTES_W-1:0]  query_bytes;
  logic [QUERY_LENGTH_W-1:0] query_length;
  fss_state_t                state;
  fss_state_t                state_next;
  logic [SCORE_W-1:0]        score;
  logic                      in_xfer;

  assign in_ready = !out_valid || out_ready;
  assign in_xfer  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      query_bytes  <= '0;
      query_length <= '0;
    end else if (cfg_write_enable) begin
      unique case (cfg_index)
        REG_QUERY_BYTES:  query_bytes  <= cfg_data;
        REG_QUERY_LENGTH: query_length <= cfg_data[QUERY_LENGTH_W-1:0];
        default: ;
      endcase
    end
  end

  fss_step #(
    .MAX_QUERY(MAX_QUERY)
  ) u_step (
    .state       (state),
    .query_bytes (query_bytes),
    .query_length(query_length),
    .text_byte   (text_byte),
    .byte_present(byte_present),
    .state_next  (state_next),
    .score       (score)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= STATE_CLEAR;
    end else if (in_xfer) begin
      state <= last_byte ? STATE_CLEAR : state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_xfer && last_byte) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer && last_byte) begin
      match_score <= score;
    end
  end

endmodule

@@ rtl/fss_checker.sv @@
// Port-level assertions for fuzzy_subsequence_score_core, attached by bind.
// Depends on fss_pkg.
`timescale 1ns / 1ps

module fss_checker
  import fss_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               last_byte,
  input logic               out_valid,
  input logic               out_ready,
  input logic [SCORE_W-1:0] match_score
);

  localparam logic [SCORE_W-1:0] SCORE_MAX = 9'd300;

  // An empty output register never blocks the input.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("in_ready low with empty output register");

  // A last transfer always produces a score in the next cycle.
  a_last_gives_result: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && last_byte) |=> out_valid)
    else $error("no score after last transfer");

  // No score appears without a last transfer.
  a_no_spurious_result: assert property (@(posedge clk) disable iff (rst)
    (!out_valid && !(in_valid && in_ready && last_byte)) |=> !out_valid)
    else $error("score without last transfer");

  // A stalled score holds its value.
  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(match_score)))
    else $error("stalled score changed");

  a_score_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (match_score <= SCORE_MAX))
    else $error("score out of range");

endmodule

bind fuzzy_subsequence_score_core fss_checker u_fss_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_ready   (in_ready),
  .last_byte  (last_byte),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .match_score(match_score)
);

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for fuzzy_subsequence_score_core: streams directed and random texts
// under changing queries, predicts each match_score and checks it. Depends on fss_pkg and fuzzy_subsequence_score_core.

import fss_pkg::*;

class match_score_board;
  logic [QUERY_BYTES_W-1:0]  query_word;
  logic [QUERY_LENGTH_W-1:0] query_len_reg;
  logic [POS_W-1:0]          matched_count;
  logic [SUM_W-1:0]          running_sum;
  bit                        last_was_hit;
  logic [CHAR_W-1:0]         last_char;
  logic [POS_W-1:0]          text_len;
  bit                        prefix_ok;
  bit                        lead_hit;
  logic [SCORE_W-1:0]        expected_scores[$];
  int                        errors;
  int                        scores_seen;

  function new();
    query_word    = '0;
    query_len_reg = '0;
    errors        = 0;
    scores_seen   = 0;
    restart();
  endfunction

  function void restart();
    matched_count = '0;
    running_sum   = '0;
    last_was_hit  = 1'b0;
    last_char     = '0;
    text_len      = '0;
    prefix_ok     = 1'b1;
    lead_hit      = 1'b0;
  endfunction

  function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [QUERY_BYTES_W-1:0] data);
    if (idx == REG_QUERY_BYTES) begin
      query_word = data;
    end else begin
      query_len_reg = data[QUERY_LENGTH_W-1:0];
    end
  endfunction

  function logic [CHAR_W-1:0] lower(logic [CHAR_W-1:0] c);
    return (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) ? (c ^ 8'h20) : c;
  endfunction

  function logic [CHAR_W-1:0] query_char(int i);
    return lower(query_word[8*i +: 8]);
  endfunction

  // Advances the stream state by one accepted transfer; a last item queues its score.
  function void note_item(logic [CHAR_W-1:0] raw, logic present, logic last);
    int                 qlen;
    logic [CHAR_W-1:0]  c;
    bit                 at_start;
    logic [SUM_W-1:0]   add;
    logic [SCORE_W-1:0] score;
    qlen = (query_len_reg > 8) ? 8 : query_len_reg;
    if (present) begin
      c = lower(raw);
      at_start = (text_len == 0);
      if (matched_count < qlen) begin
        if (c == query_char(matched_count)) begin
          add = ADD_MATCH;
          if (at_start) lead_hit = 1'b1;
          if (last_was_hit) add += ADD_RUN;
          if (at_start || last_char == CHAR_SPACE || last_char == CHAR_UNDERSCORE ||
              last_char == CHAR_HYPHEN) begin
            add += ADD_BOUNDARY;
          end
          running_sum  += add;
          last_was_hit  = 1'b1;
          matched_count++;
        end else begin
          last_was_hit = 1'b0;
        end
      end
      if (text_len < qlen && c != query_char(text_len)) prefix_ok = 1'b0;
      last_char = c;
      if (text_len < 9) text_len++;
    end
    if (last) begin
      if (qlen == 0) begin
        score = SCORE_EMPTY_Q;
      end else if (matched_count < qlen) begin
        score = SCORE_NO_MATCH;
      end else begin
        score = {1'b0, running_sum};
        if (lead_hit) score += BONUS_FIRST;
        if (prefix_ok && text_len >= qlen) score += BONUS_PREFIX;
        if (prefix_ok && text_len == qlen) score += BONUS_EXACT;
      end
      expected_scores.insert(expected_scores.size(), score);
      restart();
    end
  endfunction

  task check_score(logic [SCORE_W-1:0] got);
    logic [SCORE_W-1:0] want;
    if (expected_scores.size() == 0) begin
      report($sformatf("match_score %0d arrived with no text pending", got));
      return;
    end
    want = expected_scores.pop_front();
    scores_seen++;
    if (got !== want) report($sformatf("match_score %0d, expected %0d", got, want));
  endtask

  task report(string msg);
    $display("[%0t] MISMATCH: %s", $time, msg);
    errors++;
  endtask
endclass

module tb_top;
  localparam int CYCLE_LIMIT    = 400000;
  localparam int IDLE_SETTLE    = 4;
  localparam int ITEMS_PER_MIX  = 175;
  localparam int TEXTS_PER_QUERY = 12;

  logic                      clk;
  logic                      rst              = 1'b1;
  logic                      cfg_write_enable = 1'b0;
  logic [CFG_INDEX_W-1:0]    cfg_index        = REG_QUERY_BYTES;
  logic [QUERY_BYTES_W-1:0]  cfg_data         = '0;
  logic                      in_valid         = 1'b0;
  logic                      in_ready;
  logic [CHAR_W-1:0]         text_byte        = '0;
  logic                      byte_present     = 1'b0;
  logic                      last_byte        = 1'b0;
  logic                      out_valid;
  logic                      out_ready        = 1'b0;
  logic [SCORE_W-1:0]        match_score;

  match_score_board          sb;
  logic [CHAR_W-1:0]         text_buf[$];
  logic [QUERY_BYTES_W-1:0]  query_now = '0;
  logic [QUERY_LENGTH_W-1:0] qlen_now  = '0;
  int                        send_idle_pct = 0;
  int                        stall_pct = 0;
  int                        items_sent = 0;
  int                        settings = 0;
  int                        cycles = 0;

  fuzzy_subsequence_score_core i_dut (
    .clk              (clk),
    .rst              (rst),
    .cfg_write_enable (cfg_write_enable),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .text_byte        (text_byte),
    .byte_present     (byte_present),
    .last_byte        (last_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .match_score      (match_score)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("fuzzy_subsequence_score_core test failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // Both transfers are taken from the values sampled at the edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) sb.check_score(match_score);
      if (in_valid && in_ready) sb.note_item(text_byte, byte_present, last_byte);
    end
  end

  task automatic send_item(logic [CHAR_W-1:0] b, logic present, logic last);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    in_valid     <= 1'b1;
    text_byte    <= b;
    byte_present <= present;
    last_byte    <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (present || last) items_sent++;
  endtask

  // The first edge lets the monitor note the transfer accepted just before.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_scores.size() != 0) @(posedge clk);
    repeat (IDLE_SETTLE) @(posedge clk);
  endtask

  // Writes both registers; the length write carries random upper bits that must be ignored.
  task automatic set_query(logic [QUERY_BYTES_W-1:0] word, logic [QUERY_LENGTH_W-1:0] len);
    logic [QUERY_BYTES_W-1:0] len_data;
    len_data = {$urandom, $urandom};
    len_data[QUERY_LENGTH_W-1:0] = len;
    cfg_write_enable <= 1'b1;
    cfg_index        <= REG_QUERY_BYTES;
    cfg_data         <= word;
    @(posedge clk);
    sb.write_reg(REG_QUERY_BYTES, word);
    cfg_index <= REG_QUERY_LENGTH;
    cfg_data  <= len_data;
    @(posedge clk);
    sb.write_reg(REG_QUERY_LENGTH, len_data);
    cfg_write_enable <= 1'b0;
    query_now = word;
    qlen_now  = len;
    settings++;
  endtask

  function automatic void load_text(string s);
    text_buf.delete();
    for (int i = 0; i < s.len(); i++) text_buf.insert(text_buf.size(), s[i]);
  endfunction

  function automatic logic [CHAR_W-1:0] pick_char();
    string letters = "aAbBcC";
    string seps = " _-";
    int r;
    r = $urandom_range(19);
    if (r < 12) return letters[$urandom_range(5)];
    if (r < 16) return seps[$urandom_range(2)];
    return CHAR_W'($urandom_range(255));
  endfunction

  // Letters may arrive in either case and must still match.
  function automatic logic [CHAR_W-1:0] vary_case(logic [CHAR_W-1:0] b);
    if (((b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A)) && $urandom_range(1))
      return b ^ 8'h20;
    return b;
  endfunction

  // Mostly texts that hold the query in order (exact, as prefix, spread out),
  // some with one query byte dropped, the rest random noise.
  function automatic void build_text();
    int n;
    int style;
    int skip;
    text_buf.delete();
    n = (qlen_now > 8) ? 8 : qlen_now;
    style = $urandom_range(9);
    skip = (style == 6 && n > 0) ? $urandom_range(n - 1) : -1;
    if (n == 0 || style >= 8) begin
      repeat ($urandom_range(12)) text_buf.insert(text_buf.size(), pick_char());
    end else begin
      for (int i = 0; i < n; i++) begin
        if (style >= 2) begin
          while ($urandom_range(2) == 0) text_buf.insert(text_buf.size(), pick_char());
        end
        if (i != skip) text_buf.insert(text_buf.size(), vary_case(query_now[8*i +: 8]));
      end
      if (style == 1 || (style >= 2 && $urandom_range(1) == 1)) begin
        repeat ($urandom_range(1, 4)) text_buf.insert(text_buf.size(), pick_char());
      end
    end
  endfunction

  task automatic send_text(bit close, bit absent_end, bit sprinkle);
    int last_idx;
    last_idx = text_buf.size() - 1;
    for (int i = 0; i <= last_idx; i++) begin
      if (sprinkle && $urandom_range(9) == 0) begin
        send_item(CHAR_W'($urandom_range(255)), 1'b0, 1'b0);
      end
      send_item(text_buf[i], 1'b1, close && !absent_end && i == last_idx);
    end
    if (close && (absent_end || last_idx < 0)) begin
      send_item(CHAR_W'($urandom_range(255)), 1'b0, 1'b1);
    end
  endtask

  task automatic directed_texts();
    logic [QUERY_BYTES_W-1:0] word;
    word = 64'hDEAD_BEEF_635F_6241;
    // Empty query after reset scores one, with or without text.
    load_text("H");
    send_text(1'b1, 1'b0, 1'b0);
    send_item(8'hFF, 1'b0, 1'b1);
    wait_drained();
    set_query(word, 4'd4);
    load_text("aB_C");
    send_text(1'b1, 1'b0, 1'b0);
    // Hyphen boundary, with an absent byte inside the text.
    load_text("z-a");
    send_text(1'b0, 1'b0, 1'b0);
    send_item(8'h41, 1'b0, 1'b0);
    load_text("b_c");
    send_text(1'b1, 1'b0, 1'b0);
    send_item(8'h00, 1'b0, 1'b1);
    // The query length shrinks while a text is half through.
    load_text("ab");
    send_text(1'b0, 1'b0, 1'b0);
    wait_drained();
    set_query(word, 4'd2);
    send_item(8'h5A, 1'b0, 1'b1);
    wait_drained();
    set_query('1, 4'd15);
    text_buf.delete();
    repeat (8) text_buf.insert(text_buf.size(), 8'hFF);
    send_text(1'b1, 1'b0, 1'b0);
  endtask

  task automatic random_query();
    logic [QUERY_BYTES_W-1:0] word;
    logic [QUERY_LENGTH_W-1:0] len;
    int r;
    r = $urandom_range(19);
    if (r == 0) len = 4'd0;
    else if (r == 1) len = 4'd8;
    else if (r <= 3) len = QUERY_LENGTH_W'($urandom_range(9, 15));
    else len = QUERY_LENGTH_W'($urandom_range(1, 8));
    r = $urandom_range(9);
    if (r == 0) begin
      word = '1;
    end else if (r == 1) begin
      word = '0;
    end else if (r == 2) begin
      word = {$urandom, $urandom};
    end else begin
      for (int i = 0; i < 8; i++) word[8*i +: 8] = pick_char();
    end
    wait_drained();
    set_query(word, len);
  endtask

  task automatic random_mix(int send_pct, int stall_v);
    int start;
    int texts_here;
    send_idle_pct = send_pct;
    stall_pct <= stall_v;
    start = items_sent;
    texts_here = 0;
    while (items_sent - start < ITEMS_PER_MIX) begin
      if (texts_here % TEXTS_PER_QUERY == 0) random_query();
      build_text();
      send_text(1'b1, $urandom_range(6) == 0, 1'b1);
      texts_here++;
    end
  endtask

  initial begin
    sb = new();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    directed_texts();
    random_mix(0, 0);
    random_mix(84, 0);
    random_mix(0, 84);
    random_mix(19, 19);
    wait_drained();
    $display("Sent %0d text transfers, checked %0d scores over %0d query settings,",
             items_sent, sb.scores_seen, settings);
    $display("with no idling, a slow sender, a stalling receiver and both at once.");
    if (sb.errors == 0) begin
      $display("fuzzy_subsequence_score_core test passed");
    end else begin
      $display("fuzzy_subsequence_score_core test failed");
    end
    $finish;
  end
endmodule
